FILE: sv/sip_pkg.sv
// shared constants and control types for the segment intersection core
`default_nettype none
package sip_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // per-request control carried down the divider chain
    typedef struct packed {
        logic hit;
        logic degen;
        logic neg_x;
        logic neg_y;
    } ctl_t;

endpackage
`default_nettype wire

FILE: sv/sip_front.sv
// front stages: orientation products, hit test, ratio normalization
`default_nettype none
module sip_front #(
    parameter int CB = sip_pkg::COORD_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [8*CB-1:0]      in_coords,
    output logic                      out_valid,
    output sip_pkg::ctl_t             out_ctl,
    output logic [2*CB+1:0]           out_num,
    output logic [2*CB+1:0]           out_den,
    output logic [CB-1:0]             out_base_x,
    output logic [CB-1:0]             out_base_y,
    output logic [CB:0]               out_mag_x,
    output logic [CB:0]               out_mag_y
);
    localparam int PW = 2*CB + 2;
    localparam int NW = 2*CB + 3;
    localparam int DW = 2*CB + 2;

    typedef logic signed [CB-1:0] crd_t;
    typedef logic signed [CB:0]   dif_t;
    typedef logic signed [PW-1:0] prd_t;
    typedef logic signed [NW-1:0] crs_t;

    crd_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    crd_t c_reg [8];
    prd_t p_reg [12];
    prd_t p_next [12];
    logic v1_reg;

    // stage two signals
    crd_t qax0, qay0, qax1, qay1, qbx0, qby0, qbx1, qby1;
    crs_t x1, x2, x3, x4, xn, xd, num_n, den_a;
    logic box1, box2, box3, box4, hit;
    dif_t ddx, ddy;
    logic v2_reg;
    sip_pkg::ctl_t ctl_reg;
    logic [DW-1:0] num_reg, den_reg;
    crd_t bx_reg, by_reg;
    logic [CB:0] mx_reg, my_reg;

    function automatic dif_t sub(input crd_t a, input crd_t b);
        return dif_t'(a) - dif_t'(b);
    endfunction

    function automatic logic in_box(input crd_t ix, input crd_t iy, input crd_t jx,
                                    input crd_t jy, input crd_t kx, input crd_t ky);
        crd_t lx, hx, ly, hy;
        lx = (ix < jx) ? ix : jx;
        hx = (ix < jx) ? jx : ix;
        ly = (iy < jy) ? iy : jy;
        hy = (iy < jy) ? jy : iy;
        return (kx >= lx) && (kx <= hx) && (ky >= ly) && (ky <= hy);
    endfunction

    function automatic logic opp(input crs_t a, input crs_t b);
        return (a != '0) && (b != '0) && (a[NW-1] != b[NW-1]);
    endfunction

    assign ax0 = in_coords[0*CB +: CB];
    assign ay0 = in_coords[1*CB +: CB];
    assign ax1 = in_coords[2*CB +: CB];
    assign ay1 = in_coords[3*CB +: CB];
    assign bx0 = in_coords[4*CB +: CB];
    assign by0 = in_coords[5*CB +: CB];
    assign bx1 = in_coords[6*CB +: CB];
    assign by1 = in_coords[7*CB +: CB];

    // product terms of the four orientations, numerator and denominator
    always_comb
    begin
        p_next[0]  = sub(ax0, bx0) * sub(by1, by0);
        p_next[1]  = sub(bx1, bx0) * sub(ay0, by0);
        p_next[2]  = sub(ax1, bx0) * sub(by1, by0);
        p_next[3]  = sub(bx1, bx0) * sub(ay1, by0);
        p_next[4]  = sub(bx0, ax0) * sub(ay1, ay0);
        p_next[5]  = sub(ax1, ax0) * sub(by0, ay0);
        p_next[6]  = sub(bx1, ax0) * sub(ay1, ay0);
        p_next[7]  = sub(ax1, ax0) * sub(by1, ay0);
        p_next[8]  = sub(ax0, bx0) * sub(by0, by1);
        p_next[9]  = sub(ay0, by0) * sub(bx0, bx1);
        p_next[10] = sub(ax0, ax1) * sub(by0, by1);
        p_next[11] = sub(ay0, ay1) * sub(bx0, bx1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            c_reg[0] <= ax0;
            c_reg[1] <= ay0;
            c_reg[2] <= ax1;
            c_reg[3] <= ay1;
            c_reg[4] <= bx0;
            c_reg[5] <= by0;
            c_reg[6] <= bx1;
            c_reg[7] <= by1;
        end
    end

    // classify and normalize the ratio
    always_comb
    begin
        qax0 = c_reg[0];
        qay0 = c_reg[1];
        qax1 = c_reg[2];
        qay1 = c_reg[3];
        qbx0 = c_reg[4];
        qby0 = c_reg[5];
        qbx1 = c_reg[6];
        qby1 = c_reg[7];
        x1 = crs_t'(p_reg[0]) - crs_t'(p_reg[1]);
        x2 = crs_t'(p_reg[2]) - crs_t'(p_reg[3]);
        x3 = crs_t'(p_reg[4]) - crs_t'(p_reg[5]);
        x4 = crs_t'(p_reg[6]) - crs_t'(p_reg[7]);
        xn = crs_t'(p_reg[8]) - crs_t'(p_reg[9]);
        xd = crs_t'(p_reg[10]) - crs_t'(p_reg[11]);
        box1 = (x1 == '0) && in_box(qbx0, qby0, qbx1, qby1, qax0, qay0);
        box2 = (x2 == '0) && in_box(qbx0, qby0, qbx1, qby1, qax1, qay1);
        box3 = (x3 == '0) && in_box(qax0, qay0, qax1, qay1, qbx0, qby0);
        box4 = (x4 == '0) && in_box(qax0, qay0, qax1, qay1, qbx1, qby1);
        hit = (opp(x1, x2) && opp(x3, x4)) || box1 || box2 || box3 || box4;
        den_a = xd[NW-1] ? -xd : xd;
        num_n = xd[NW-1] ? -xn : xn;
        if (num_n[NW-1])
        begin
            num_n = '0;
        end
        else if (num_n > den_a)
        begin
            num_n = den_a;
        end
        ddx = sub(qax1, qax0);
        ddy = sub(qay1, qay0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg.hit   <= hit;
            ctl_reg.degen <= hit && (xd == '0);
            ctl_reg.neg_x <= ddx[CB];
            ctl_reg.neg_y <= ddy[CB];
            num_reg <= num_n[DW-1:0];
            den_reg <= den_a[DW-1:0];
            bx_reg  <= qax0;
            by_reg  <= qay0;
            mx_reg  <= ddx[CB] ? (CB+1)'(-ddx) : ddx;
            my_reg  <= ddy[CB] ? (CB+1)'(-ddy) : ddy;
        end
    end

    assign out_valid  = v2_reg;
    assign out_ctl    = ctl_reg;
    assign out_num    = num_reg;
    assign out_den    = den_reg;
    assign out_base_x = bx_reg;
    assign out_base_y = by_reg;
    assign out_mag_x  = mx_reg;
    assign out_mag_y  = my_reg;

endmodule
`default_nettype wire

FILE: sv/sip_cell.sv
// one divider cell: retires one bit of the scaled offset for x and y
`default_nettype none
module sip_cell #(
    parameter int CB  = sip_pkg::COORD_BITS_DEF,
    parameter int BIT = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  sip_pkg::ctl_t      in_ctl,
    input  wire logic [2*CB+1:0] in_num,
    input  wire logic [2*CB+1:0] in_den,
    input  wire logic [CB-1:0] in_base_x,
    input  wire logic [CB-1:0] in_base_y,
    input  wire logic [CB:0]   in_mag_x,
    input  wire logic [CB:0]   in_mag_y,
    input  wire logic [CB:0]   in_q_x,
    input  wire logic [CB:0]   in_q_y,
    input  wire logic [2*CB+1:0] in_r_x,
    input  wire logic [2*CB+1:0] in_r_y,
    output logic               out_valid,
    output sip_pkg::ctl_t      out_ctl,
    output logic [2*CB+1:0]    out_num,
    output logic [2*CB+1:0]    out_den,
    output logic [CB-1:0]      out_base_x,
    output logic [CB-1:0]      out_base_y,
    output logic [CB:0]        out_mag_x,
    output logic [CB:0]        out_mag_y,
    output logic [CB:0]        out_q_x,
    output logic [CB:0]        out_q_y,
    output logic [2*CB+1:0]    out_r_x,
    output logic [2*CB+1:0]    out_r_y
);
    localparam int DW = 2*CB + 2;
    localparam int RW = DW + 1;

    logic                 v_reg;
    sip_pkg::ctl_t        ctl_reg;
    logic [DW-1:0]        num_reg, den_reg, rx_reg, ry_reg, rx_next, ry_next;
    logic [CB-1:0]        bx_reg, by_reg;
    logic [CB:0]          mx_reg, my_reg, qx_reg, qy_reg, qx_next, qy_next;

    // shift remainder, subtract, then add numerator on a set bit and subtract
    function automatic logic [RW+CB-1:0] step(input logic [DW-1:0] r, input logic [CB:0] q,
                                             input logic bitv, input logic [DW-1:0] num,
                                             input logic [DW-1:0] den);
        logic [RW-1:0] t;
        logic [CB:0]   qq;
        t  = {r, 1'b0};
        qq = {q[CB-1:0], 1'b0};
        if (t >= {1'b0, den})
        begin
            t  = t - {1'b0, den};
            qq = qq + 1'b1;
        end
        if (bitv)
        begin
            t = t + {1'b0, num};
            if (t >= {1'b0, den})
            begin
                t  = t - {1'b0, den};
                qq = qq + 1'b1;
            end
        end
        return {t[DW-1:0], qq};
    endfunction

    always_comb
    begin
        {rx_next, qx_next} = step(in_r_x, in_q_x, in_mag_x[BIT], in_num, in_den);
        {ry_next, qy_next} = step(in_r_y, in_q_y, in_mag_y[BIT], in_num, in_den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            num_reg <= in_num;
            den_reg <= in_den;
            bx_reg  <= in_base_x;
            by_reg  <= in_base_y;
            mx_reg  <= in_mag_x;
            my_reg  <= in_mag_y;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
        end
    end

    assign out_valid  = v_reg;
    assign out_ctl    = ctl_reg;
    assign out_num    = num_reg;
    assign out_den    = den_reg;
    assign out_base_x = bx_reg;
    assign out_base_y = by_reg;
    assign out_mag_x  = mx_reg;
    assign out_mag_y  = my_reg;
    assign out_q_x    = qx_reg;
    assign out_q_y    = qy_reg;
    assign out_r_x    = rx_reg;
    assign out_r_y    = ry_reg;

endmodule
`default_nettype wire

FILE: sv/segment_intersection_point_core.sv
// segment intersection core: front stages, divider cell chain, output register
// throughput: one request per cycle; two front stages, one cell per offset bit,
// and one output register, all advancing together while the output can move
// reset: rst_n clears every valid bit asynchronously; no other state is reset
`default_nettype none
module segment_intersection_point_core #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // cross_x, cross_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
    // hit, degenerate
    output logic [1:0]                                  m_axis_tuser
);
    localparam int CB  = COORD_BITS;
    localparam int DB  = CB + 1;
    localparam int DW  = 2*CB + 2;
    localparam int OW  = ((2*CB+7)/8)*8;

    logic en;

    logic                v_s   [DB+1];
    sip_pkg::ctl_t       ctl_s [DB+1];
    logic [DW-1:0]       num_s [DB+1];
    logic [DW-1:0]       den_s [DB+1];
    logic [CB-1:0]       bx_s  [DB+1];
    logic [CB-1:0]       by_s  [DB+1];
    logic [CB:0]         mx_s  [DB+1];
    logic [CB:0]         my_s  [DB+1];
    logic [CB:0]         qx_s  [DB+1];
    logic [CB:0]         qy_s  [DB+1];
    logic [DW-1:0]       rx_s  [DB+1];
    logic [DW-1:0]       ry_s  [DB+1];

    logic                ov_reg;
    logic [1:0]          flags_reg;
    logic [CB-1:0]       ox_reg, oy_reg, ox_next, oy_next;

    // whole pipeline moves when the output register is free or being taken
    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    sip_front #(.CB(CB)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .in_coords  (s_axis_tdata[8*CB-1:0]),
        .out_valid  (v_s[0]),
        .out_ctl    (ctl_s[0]),
        .out_num    (num_s[0]),
        .out_den    (den_s[0]),
        .out_base_x (bx_s[0]),
        .out_base_y (by_s[0]),
        .out_mag_x  (mx_s[0]),
        .out_mag_y  (my_s[0])
    );

    assign qx_s[0] = '0;
    assign qy_s[0] = '0;
    assign rx_s[0] = '0;
    assign ry_s[0] = '0;

    // divider chain, most significant offset bit first
    for (genvar i = 0; i < DB; i++)
    begin : g_cell
        sip_cell #(.CB(CB), .BIT(DB-1-i)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (v_s[i]),
            .in_ctl     (ctl_s[i]),
            .in_num     (num_s[i]),
            .in_den     (den_s[i]),
            .in_base_x  (bx_s[i]),
            .in_base_y  (by_s[i]),
            .in_mag_x   (mx_s[i]),
            .in_mag_y   (my_s[i]),
            .in_q_x     (qx_s[i]),
            .in_q_y     (qy_s[i]),
            .in_r_x     (rx_s[i]),
            .in_r_y     (ry_s[i]),
            .out_valid  (v_s[i+1]),
            .out_ctl    (ctl_s[i+1]),
            .out_num    (num_s[i+1]),
            .out_den    (den_s[i+1]),
            .out_base_x (bx_s[i+1]),
            .out_base_y (by_s[i+1]),
            .out_mag_x  (mx_s[i+1]),
            .out_mag_y  (my_s[i+1]),
            .out_q_x    (qx_s[i+1]),
            .out_q_y    (qy_s[i+1]),
            .out_r_x    (rx_s[i+1]),
            .out_r_y    (ry_s[i+1])
        );
    end

    // base plus or minus quotient, truncated toward zero
    function automatic logic [CB-1:0] fin(input logic [CB-1:0] base, input logic neg,
                                          input logic [CB:0] q, input logic rnz);
        logic signed [CB+1:0] ip;
        if (!neg)
        begin
            ip = $signed({{2{base[CB-1]}}, base}) + $signed({1'b0, q});
            if (ip < 0 && rnz)
            begin
                ip = ip + 2'sd1;
            end
        end
        else
        begin
            ip = $signed({{2{base[CB-1]}}, base}) - $signed({1'b0, q});
            if (ip > 0 && rnz)
            begin
                ip = ip - 2'sd1;
            end
        end
        return ip[CB-1:0];
    endfunction

    always_comb
    begin
        if (!ctl_s[DB].hit)
        begin
            ox_next = '0;
            oy_next = '0;
        end
        else if (ctl_s[DB].degen)
        begin
            ox_next = bx_s[DB];
            oy_next = by_s[DB];
        end
        else
        begin
            ox_next = fin(bx_s[DB], ctl_s[DB].neg_x, qx_s[DB], rx_s[DB] != '0);
            oy_next = fin(by_s[DB], ctl_s[DB].neg_y, qy_s[DB], ry_s[DB] != '0);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= v_s[DB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= {ctl_s[DB].degen, ctl_s[DB].hit};
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = flags_reg;
    assign m_axis_tdata  = OW'({oy_reg, ox_reg});

`ifndef NO_ASSERTIONS
    a_degen_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("degenerate without hit");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("point nonzero on miss");
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_s[DB] |=> m_axis_tvalid)
        else $error("chain result lost");
`endif

endmodule
`default_nettype wire
